FILE: rtl/core/expt_pkg.sv
// Shared types and constants of the expression tokenizer.
// No dependencies; expt_lex_step, expt_token_queue and the top level import it.
`timescale 1ns / 1ps
`default_nettype none

package expt_pkg;

   localparam int NUMBER_WIDTH = 32;   // accumulator and number_value width
   localparam int MAX_TOKENS   = 3;    // results one text byte can cause
   localparam int QUEUE_DEPTH  = 8;    // token queue entries
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int PUSH_CNT_W   = $clog2(MAX_TOKENS + 1);

   typedef enum logic [2:0] {
      KIND_NUMBER   = 3'd0,
      KIND_OPERATOR = 3'd1,
      KIND_OPEN     = 3'd2,
      KIND_CLOSE    = 3'd3,
      KIND_VARIABLE = 3'd4,
      KIND_FUNCTION = 3'd5,
      KIND_END      = 3'd6
   } kind_type;

   typedef enum logic [1:0] {
      FUNC_SIN = 2'd0,
      FUNC_COS = 2'd1,
      FUNC_TAN = 2'd2
   } func_type;

   // keyword prefix matched so far; code 7 is unused and reads as none
   typedef enum logic [2:0] {
      PFX_NONE = 3'd0,
      PFX_S    = 3'd1,
      PFX_SI   = 3'd2,
      PFX_C    = 3'd3,
      PFX_CO   = 3'd4,
      PFX_T    = 3'd5,
      PFX_TA   = 3'd6
   } prefix_type;

   typedef struct packed {
      logic [NUMBER_WIDTH-1:0] accumulator;
      logic                    pending;
      logic                    saturated;
      prefix_type              prefix;
   } lex_state_type;

   typedef struct packed {
      kind_type                token_kind;
      logic [NUMBER_WIDTH-1:0] number_value;
      logic                    number_overflow;
      logic [7:0]              symbol_char;
      func_type                function_code;
      logic                    last_of_run;
   } token_type;

endpackage : expt_pkg

`default_nettype wire

FILE: rtl/core/expt_channels.sv
// Handshake interfaces for the byte input and the token output channels.
// Depends on nothing; widths follow the token fields of expt_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface expt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface : expt_req_if

interface expt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  token_kind;
   logic [31:0] number_value;
   logic        number_overflow;
   logic [7:0]  symbol_char;
   logic [1:0]  function_code;
   logic        last_of_run;

   modport source (output valid, output token_kind, output number_value,
                   output number_overflow, output symbol_char, output function_code,
                   output last_of_run, input ready);
   modport sink   (input valid, input token_kind, input number_value,
                   input number_overflow, input symbol_char, input function_code,
                   input last_of_run, output ready);
endinterface : expt_rsp_if

`default_nettype wire

FILE: rtl/core/expt_lex_step.sv
// Single-byte lexer step: next state and up to three tokens for one byte.
// Purely combinational; depends on expt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module expt_lex_step
   import expt_pkg::*;
(
   input  wire logic [7:0]                  text_byte,
   input  wire logic                        end_of_text,
   input  wire lex_state_type               state_cur,
   output lex_state_type                    state_nxt,
   output token_type [MAX_TOKENS-1:0]       tokens,
   output logic [PUSH_CNT_W-1:0]            token_count
);

   localparam logic [NUMBER_WIDTH-1:0] NumMax = '1;

   logic                    is_digit;
   logic [NUMBER_WIDTH+3:0] scaled;
   logic                    sat_hit;
   logic                    num_emit;
   token_type               num_tok;
   logic                    own_emit;
   token_type               own_tok;
   logic                    consumed;
   logic [7:0]              expect_char;
   prefix_type              next_prefix;
   logic                    completes;
   func_type                func_code;

   assign is_digit = (text_byte >= "0") && (text_byte <= "9");
   // acc * 10 + digit, wide enough to see the overflow
   assign scaled = {state_cur.accumulator, 3'b000} + {2'b00, state_cur.accumulator, 1'b0}
                 + {{(NUMBER_WIDTH){1'b0}}, text_byte[3:0]};
   assign sat_hit = state_cur.saturated || (scaled[NUMBER_WIDTH+3:NUMBER_WIDTH] != 4'd0);

   // keyword table
   always_comb begin
      expect_char = 8'd0;
      next_prefix = PFX_NONE;
      completes   = 1'b0;
      func_code   = FUNC_SIN;
      unique case (state_cur.prefix)
         PFX_S:  begin expect_char = "i"; next_prefix = PFX_SI; end
         PFX_SI: begin expect_char = "n"; completes = 1'b1; func_code = FUNC_SIN; end
         PFX_C:  begin expect_char = "o"; next_prefix = PFX_CO; end
         PFX_CO: begin expect_char = "s"; completes = 1'b1; func_code = FUNC_COS; end
         PFX_T:  begin expect_char = "a"; next_prefix = PFX_TA; end
         PFX_TA: begin expect_char = "n"; completes = 1'b1; func_code = FUNC_TAN; end
         default: begin expect_char = 8'd0; end
      endcase
   end

   always_comb begin
      state_nxt = state_cur;
      num_emit  = 1'b0;
      num_tok   = '0;
      own_emit  = 1'b0;
      own_tok   = '0;
      consumed  = 1'b0;

      if (is_digit) begin
         state_nxt.prefix  = PFX_NONE;
         state_nxt.pending = 1'b1;
         if (sat_hit) begin
            state_nxt.accumulator = NumMax;
            state_nxt.saturated   = 1'b1;
         end else begin
            state_nxt.accumulator = scaled[NUMBER_WIDTH-1:0];
         end
      end else begin
         // flush the number that this byte ends
         if (state_cur.pending) begin
            num_emit                = 1'b1;
            num_tok.token_kind      = KIND_NUMBER;
            num_tok.number_value    = state_cur.accumulator;
            num_tok.number_overflow = state_cur.saturated;
         end
         state_nxt.accumulator = '0;
         state_nxt.pending     = 1'b0;
         state_nxt.saturated   = 1'b0;
         state_nxt.prefix      = PFX_NONE;

         if (expect_char != 8'd0 && text_byte == expect_char) begin
            consumed         = 1'b1;
            state_nxt.prefix = next_prefix;
            if (completes) begin
               own_emit              = 1'b1;
               own_tok.token_kind    = KIND_FUNCTION;
               own_tok.function_code = func_code;
            end
         end

         // failed or absent prefix: test the byte as a fresh start
         if (!consumed) begin
            case (text_byte) inside
               "s": state_nxt.prefix = PFX_S;
               "c": state_nxt.prefix = PFX_C;
               "t": state_nxt.prefix = PFX_T;
               "+", "-", "*", "/", "^": begin
                  own_emit            = 1'b1;
                  own_tok.token_kind  = KIND_OPERATOR;
                  own_tok.symbol_char = text_byte;
               end
               "(", "{", "[": begin
                  own_emit            = 1'b1;
                  own_tok.token_kind  = KIND_OPEN;
                  own_tok.symbol_char = text_byte;
               end
               ")", "}", "]": begin
                  own_emit            = 1'b1;
                  own_tok.token_kind  = KIND_CLOSE;
                  own_tok.symbol_char = text_byte;
               end
               "x", "y": begin
                  own_emit            = 1'b1;
                  own_tok.token_kind  = KIND_VARIABLE;
                  own_tok.symbol_char = text_byte;
               end
               default: ;
            endcase
         end
      end

      // end of text: flush the number that this digit completed, reset all
      if (end_of_text) begin
         if (is_digit) begin
            num_emit                = 1'b1;
            num_tok                 = '0;
            num_tok.token_kind      = KIND_NUMBER;
            num_tok.number_value    = state_nxt.accumulator;
            num_tok.number_overflow = state_nxt.saturated;
         end
         state_nxt = '0;
      end
   end

   // pack in order: number, own token, end
   always_comb begin
      tokens      = '0;
      token_count = '0;
      if (num_emit) begin
         tokens[token_count[1:0]] = num_tok;
         token_count              = token_count + PUSH_CNT_W'(1);
      end
      if (own_emit) begin
         tokens[token_count[1:0]] = own_tok;
         token_count              = token_count + PUSH_CNT_W'(1);
      end
      if (end_of_text) begin
         tokens[token_count[1:0]]            = '0;
         tokens[token_count[1:0]].token_kind = KIND_END;
         token_count                         = token_count + PUSH_CNT_W'(1);
      end
      if (token_count != '0) begin
         tokens[token_count[1:0] - 2'd1].last_of_run = 1'b1;
      end
   end

endmodule : expt_lex_step

`default_nettype wire

FILE: rtl/core/expt_token_queue.sv
// Token queue: takes up to three tokens per cycle, hands out one per cycle when popped.
// Depends on expt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module expt_token_queue
   import expt_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [PUSH_CNT_W-1:0]       push_count,
   input  wire token_type [MAX_TOKENS-1:0]  push_tokens,
   output logic                             has_room,
   output logic                             head_valid,
   output token_type                        head_token,
   input  wire logic                        pop
);

   token_type                mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff,  count_in;
   logic                     do_pop;

   assign has_room   = count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - MAX_TOKENS);
   assign head_valid = count_ff != '0;
   assign head_token = mem[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   assign wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(push_count);
   assign rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(do_pop);
   assign count_in  = count_ff + QUEUE_CNT_W'(push_count) - QUEUE_CNT_W'(do_pop);

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_TOKENS; i++) begin
         if (PUSH_CNT_W'(i) < push_count) begin
            mem[wr_ptr_ff + QUEUE_PTR_W'(i)] <= push_tokens[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule : expt_token_queue

`default_nettype wire

FILE: rtl/core/expression_tokenizer.sv
// Expression tokenizer top level: byte input, lexer state, token queue.
// Depends on expt_pkg, expt_channels, expt_lex_step and expt_token_queue.
`timescale 1ns / 1ps
`default_nettype none

// Takes expression text one byte per word on req_bus and returns tokens on
// rsp_bus: numbers (as saturated 32-bit values with an overflow flag),
// operators, brackets, the variables x and y, and the functions sin, cos and
// tan; the byte marked end_of_text flushes any pending number and adds an end
// token. A byte is accepted in every cycle while the 8-entry token queue has
// room for three more tokens; the lexer decodes it in that same cycle and its
// tokens are registered into the queue behind any older tokens. One byte
// yields at most three tokens, and the queue hands out one token per cycle
// while rsp_bus is ready, so text that produces more than one token per byte
// on average is paced by the output port. Bytes that start or continue nothing
// add no token of their own. last_of_run marks the last token of a byte.

module expression_tokenizer
   import expt_pkg::*;
(
   input wire logic   clock,
   input wire logic   reset,
   expt_req_if.sink   req_bus,
   expt_rsp_if.source rsp_bus
);

   lex_state_type              state_ff, state_in;
   lex_state_type              step_state;
   token_type [MAX_TOKENS-1:0] step_tokens;
   logic [PUSH_CNT_W-1:0]      step_count;
   logic [PUSH_CNT_W-1:0]      push_count;
   logic                       queue_room;
   logic                       accept;
   logic                       head_valid;
   token_type                  head_token;

   // take a byte only when its worst-case burst of tokens fits
   assign req_bus.ready = queue_room;
   assign accept        = req_bus.valid && queue_room;

   expt_lex_step u_lex_step (
      .text_byte   (req_bus.text_byte),
      .end_of_text (req_bus.end_of_text),
      .state_cur   (state_ff),
      .state_nxt   (step_state),
      .tokens      (step_tokens),
      .token_count (step_count)
   );

   // advance the lexer state only on an accepted word, hold it otherwise
   assign state_in   = accept ? step_state : state_ff;
   assign push_count = accept ? step_count : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   expt_token_queue u_token_queue (
      .clock       (clock),
      .reset       (reset),
      .push_count  (push_count),
      .push_tokens (step_tokens),
      .has_room    (queue_room),
      .head_valid  (head_valid),
      .head_token  (head_token),
      .pop         (rsp_bus.ready)
   );

   // present the oldest token; drop it from the queue once taken
   assign rsp_bus.valid           = head_valid;
   assign rsp_bus.token_kind      = head_token.token_kind;
   assign rsp_bus.number_value    = head_token.number_value[31:0];
   assign rsp_bus.number_overflow = head_token.number_overflow;
   assign rsp_bus.symbol_char     = head_token.symbol_char;
   assign rsp_bus.function_code   = head_token.function_code;
   assign rsp_bus.last_of_run     = head_token.last_of_run;

endmodule : expression_tokenizer

`default_nettype wire
